// ===== src/scfb_pkg.sv =====
// Shared types, constants and helpers for the size class free block cache.
// Used by every module under src; depends on nothing.
`default_nettype none

package scfb_pkg;

  // Geometry of the cache
  localparam int NUM_CLASSES = 9;
  localparam int STACK_DEPTH = 128;
  localparam int ADDR_WIDTH  = 32;

  localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CMP_W     = (FILL_W > 8) ? FILL_W : 8;

  // Command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // Configuration register
  localparam logic [7:0] MAX_HELD_RESET = 8'd100;
  localparam logic       REG_MAX_HELD   = 1'b0;

  // Class encodings for big blocks
  localparam logic [5:0] SIZE_CLASS_BIG    = 6'h3F;
  localparam logic [4:0] RELEASE_CLASS_BIG = 5'h1F;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_BIG       = 3'd2,
    ST_ZERO      = 3'd3,
    ST_CACHED    = 3'd4,
    ST_MUST_FREE = 3'd5,
    ST_INVALID   = 3'd6,
    ST_NULL      = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    OP_DONE = 2'd0,
    OP_POP  = 2'd1,
    OP_PUSH = 2'd2
  } op_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_e;

  // Classified command handed from the front to the back
  typedef struct packed {
    op_e                   op;
    status_e               status;
    logic [CLS_W-1:0]      cls;
    logic [ADDR_WIDTH-1:0] addr;
    logic [5:0]            size_class;
    logic [31:0]           bytes;
  } cmd_t;

  // Index of the highest set bit, 0 for values of 0 or 1
  function automatic logic [4:0] top_bit(input logic [31:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        r = i[4:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/scfb_front.sv =====
// Front end: classifies each incoming item into a command for the back end.
// Depends on scfb_pkg.
`default_nettype none

module scfb_front (
  input  wire logic         mode_i,
  input  wire logic [31:0]  request_size_i,
  input  wire logic [31:0]  block_address_i,
  input  wire logic [4:0]   block_class_i,
  output scfb_pkg::cmd_t    cmd_o
);
  import scfb_pkg::*;

  logic [4:0]            tb;
  logic [31:0]           size_m1;
  logic [ADDR_WIDTH-1:0] rel_addr;
  logic                  rel_valid_cls;

  assign size_m1       = request_size_i - 32'd1;
  assign tb            = top_bit(size_m1);
  assign rel_addr      = block_address_i[ADDR_WIDTH-1:0];
  assign rel_valid_cls = !block_class_i[4] && (int'(block_class_i[3:0]) < NUM_CLASSES);

  // Decode the item into a finished result or a stack operation
  always_comb begin
    cmd_o            = '0;
    cmd_o.op         = OP_DONE;
    cmd_o.status     = ST_ZERO;
    if (!mode_i) begin
      if (request_size_i == 32'd0) begin
        cmd_o.status = ST_ZERO;
      end else if (int'(tb) >= NUM_CLASSES) begin
        cmd_o.status     = ST_BIG;
        cmd_o.size_class = SIZE_CLASS_BIG;
        cmd_o.bytes      = request_size_i;
      end else begin
        cmd_o.op         = OP_POP;
        cmd_o.status     = ST_MISS;
        cmd_o.cls        = tb[CLS_W-1:0];
        cmd_o.size_class = {1'b0, tb};
        cmd_o.bytes      = 32'd2 << tb;
      end
    end else begin
      if (rel_addr == '0) begin
        cmd_o.status = ST_NULL;
      end else if (block_class_i == RELEASE_CLASS_BIG) begin
        cmd_o.status = ST_MUST_FREE;
      end else if (rel_valid_cls) begin
        cmd_o.op     = OP_PUSH;
        cmd_o.status = ST_CACHED;
        cmd_o.cls    = block_class_i[CLS_W-1:0];
        cmd_o.addr   = rel_addr;
      end else begin
        cmd_o.status = ST_INVALID;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/scfb_cmd_fifo.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on scfb_pkg.
`default_nettype none

module scfb_cmd_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire scfb_pkg::cmd_t data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output scfb_pkg::cmd_t    data_o,
  output logic              empty_o
);
  import scfb_pkg::*;

  cmd_t                 entry_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] count_q, count_d;
  logic                 do_wr, do_rd;

  assign full_o  = (count_q == CMD_CNT_W'(CMD_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + CMD_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + CMD_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + CMD_CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the written entry
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/scfb_back.sv =====
// Back end: per-class fill counts, the free address stack memory and the
// result register. Depends on scfb_pkg.
`default_nettype none

module scfb_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [7:0]               max_held_i,
  input  wire logic                     cmd_valid_i,
  input  wire scfb_pkg::cmd_t           cmd_i,
  output logic                          cmd_pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_pop_i,
  output scfb_pkg::status_e             status_o,
  output logic [scfb_pkg::ADDR_WIDTH-1:0] granted_address_o,
  output logic [5:0]                    size_class_o,
  output logic [31:0]                   granted_bytes_o
);
  import scfb_pkg::*;

  back_state_e           state_q, state_d;
  logic [FILL_W-1:0]     fill_q [NUM_CLASSES];
  logic [ADDR_WIDTH-1:0] mem [MEM_DEPTH];
  logic [ADDR_WIDTH-1:0] rd_data_q;
  logic [5:0]            pend_class_q;
  logic [31:0]           pend_bytes_q;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [ADDR_WIDTH-1:0] out_addr_q, out_addr_d;
  logic [5:0]            out_class_q, out_class_d;
  logic [31:0]           out_bytes_q, out_bytes_d;

  logic                  issue, hit, room, do_push, do_pop, out_load;
  logic [FILL_W-1:0]     cur_fill;
  logic [CMP_W-1:0]      limit;
  logic [MEM_AW-1:0]     base_idx, wr_idx, rd_idx;

  // Limit in effect is the smaller of the register and the stack depth
  assign limit = (CMP_W'(max_held_i) >= CMP_W'(STACK_DEPTH)) ? CMP_W'(STACK_DEPTH)
                                                            : CMP_W'(max_held_i);

  assign cur_fill = fill_q[cmd_i.cls];
  assign issue    = (state_q == BK_IDLE) && cmd_valid_i && (!out_valid_q || out_pop_i);
  assign hit      = (cmd_i.op == OP_POP) && (cur_fill != '0);
  assign room     = CMP_W'(cur_fill) < limit;
  assign do_push  = issue && (cmd_i.op == OP_PUSH) && room;
  assign do_pop   = issue && hit;

  assign base_idx = MEM_AW'(int'(cmd_i.cls) * STACK_DEPTH);
  assign wr_idx   = base_idx + MEM_AW'(cur_fill[PTR_W-1:0]);
  assign rd_idx   = base_idx + MEM_AW'(cur_fill - FILL_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (do_pop) begin
          state_d = BK_READ;
        end
      end
      BK_READ: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer: command pop and result load
  always_comb begin
    cmd_pop_o    = 1'b0;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_class_d  = out_class_q;
    out_bytes_d  = out_bytes_q;
    case (state_q)
      BK_IDLE: begin
        cmd_pop_o = issue;
        if (issue && !hit) begin
          out_load    = 1'b1;
          out_addr_d  = '0;
          out_class_d = cmd_i.size_class;
          out_bytes_d = cmd_i.bytes;
          case (cmd_i.op)
            OP_POP:  out_status_d = ST_MISS;
            OP_PUSH: out_status_d = room ? ST_CACHED : ST_MUST_FREE;
            default: out_status_d = cmd_i.status;
          endcase
        end
      end
      BK_READ: begin
        out_load     = 1'b1;
        out_status_d = ST_HIT;
        out_addr_d   = rd_data_q;
        out_class_d  = pend_class_q;
        out_bytes_d  = pend_bytes_q;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_pop_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (do_push) begin
        fill_q[cmd_i.cls] <= cur_fill + FILL_W'(1);
      end else if (do_pop) begin
        fill_q[cmd_i.cls] <= cur_fill - FILL_W'(1);
      end
    end
  end

  // Hold result payload and the fields of a pending hit
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_addr_q   <= out_addr_d;
      out_class_q  <= out_class_d;
      out_bytes_q  <= out_bytes_d;
    end
    if (do_pop) begin
      pend_class_q <= cmd_i.size_class;
      pend_bytes_q <= cmd_i.bytes;
    end
  end

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_idx] <= cmd_i.addr;
    end
    if (do_pop) begin
      rd_data_q <= mem[rd_idx];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign granted_address_o = out_addr_q;
  assign size_class_o      = out_class_q;
  assign granted_bytes_o   = out_bytes_q;

`ifndef SYNTHESIS
  // The result slot is free while a hit read is in flight
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_READ |-> !out_valid_q)
    else $error("result slot busy during stack read");

  // A hit read always lands in the result register next cycle
  a_read_fills_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_READ |=> out_valid_q && out_status_q == ST_HIT)
    else $error("hit result not delivered after stack read");

  // Commands are only taken while the sequencer is idle
  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == BK_IDLE && cmd_valid_i)
    else $error("command popped outside idle state");

  // A push never grows the stack past the stack depth
  a_push_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |-> CMP_W'(cur_fill) < CMP_W'(STACK_DEPTH))
    else $error("push beyond stack depth");
`endif

endmodule

`default_nettype wire

// ===== src/size_class_free_block_cache_top.sv =====
// Top level of the size class free block cache: configuration register,
// front classifier, command queue and back end. Depends on scfb_pkg and the
// scfb_front, scfb_cmd_fifo and scfb_back modules.
// An item passes the command queue, then the result register; a cache hit also
// waits for the registered stack memory read. Throughput: one item per cycle
// while results are popped; a cache hit holds the back end during that read.
// Reset: asynchronous active low; all stacks read empty and the per-class limit
// returns to 100. Stack memory contents are not cleared.
`default_nettype none

module size_class_free_block_cache_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Item queue side
  input  wire logic         push,
  output logic              full,
  input  wire logic         mode_i,
  input  wire logic [31:0]  request_size_i,
  input  wire logic [31:0]  block_address_i,
  input  wire logic [4:0]   block_class_i,
  // Result queue side
  output logic              empty,
  input  wire logic         pop,
  output logic [2:0]        status_o,
  output logic [31:0]       granted_address_o,
  output logic [5:0]        size_class_o,
  output logic [31:0]       granted_bytes_o,
  // Configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import scfb_pkg::*;

  logic                  cfg_wr;
  logic [7:0]            max_held_q;
  cmd_t                  front_cmd, fifo_cmd;
  logic                  fifo_empty, fifo_pop, out_valid;
  status_e               back_status;
  logic [ADDR_WIDTH-1:0] back_addr;

  // Configuration register write and readback
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MAX_HELD) ? {24'd0, max_held_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_held_q <= MAX_HELD_RESET;
    end else if (cfg_wr && paddr[2] == REG_MAX_HELD) begin
      max_held_q <= pwdata[7:0];
    end
  end

  scfb_front u_front (
    .mode_i          (mode_i),
    .request_size_i  (request_size_i),
    .block_address_i (block_address_i),
    .block_class_i   (block_class_i),
    .cmd_o           (front_cmd)
  );

  scfb_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (fifo_pop),
    .data_o  (fifo_cmd),
    .empty_o (fifo_empty)
  );

  scfb_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .max_held_i        (max_held_q),
    .cmd_valid_i       (!fifo_empty),
    .cmd_i             (fifo_cmd),
    .cmd_pop_o         (fifo_pop),
    .out_valid_o       (out_valid),
    .out_pop_i         (pop),
    .status_o          (back_status),
    .granted_address_o (back_addr),
    .size_class_o      (size_class_o),
    .granted_bytes_o   (granted_bytes_o)
  );

  assign empty             = !out_valid;
  assign status_o          = back_status;
  assign granted_address_o = 32'(back_addr);

endmodule

`default_nettype wire
